>>> rtl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int CFG_W       = 17;
    localparam int PAL_AW      = 8;
    localparam int PAL_DEPTH   = 256;
    localparam int COLOR_W     = 24;
    localparam int OUT_COORD_W = 16;
    localparam int COUNT_W     = 6;

    localparam logic FUNC_PALETTE = 1'b0;
    localparam logic FUNC_IMAGE   = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] RUN_MARK = 8'hC0;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 17'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 17'd200;

    typedef struct packed {
        logic               func;
        logic [7:0]         data_byte;
        logic [PAL_AW-1:0]  palette_index;
        logic [COLOR_W-1:0] palette_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [OUT_COORD_W-1:0] column;
        logic [OUT_COORD_W-1:0] row;
        logic                   run_last;
        logic                   image_done;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic finished;
        logic push;
    } t_status;

    typedef struct packed {
        logic               wr_en;
        logic [PAL_AW-1:0]  wr_addr;
        logic [COLOR_W-1:0] wr_data;
        logic               rd_en;
        logic [PAL_AW-1:0]  rd_addr;
    } t_pal_req;

endpackage

>>> rtl/pcxrle_pal_ram.sv
// ----------------------------------------------------------------------------
// pcxrle_pal_ram
// 256 x 24 palette memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcxrle_pal_ram (
    input  logic                          i_clk,
    input  pcxrle_pkg::t_pal_req          i_req,
    output logic [pcxrle_pkg::COLOR_W-1:0] o_rdata
);

    logic [pcxrle_pkg::COLOR_W-1:0] r_mem [pcxrle_pkg::PAL_DEPTH];
    logic [pcxrle_pkg::COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pcxrle_ctl.sv
// ----------------------------------------------------------------------------
// pcxrle_ctl
// Byte parser, run sequencer and output register of the decoder.
// ----------------------------------------------------------------------------
module pcxrle_ctl #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pcxrle_pkg::t_in_item           i_in_data,
    input  logic [COORD_BITS:0]            i_width,
    input  logic [COORD_BITS:0]            i_height,
    output pcxrle_pkg::t_pal_req           o_pal_req,
    input  logic [pcxrle_pkg::COLOR_W-1:0] i_pal_rdata,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pcxrle_pkg::t_out_item          o_out_data,
    output pcxrle_pkg::t_status            o_status
);

    localparam int CW = COORD_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_WRAP
    } t_state;

    t_state                              r_state;
    logic                                r_await;
    logic [pcxrle_pkg::COUNT_W-1:0]      r_pending;
    logic [CW-1:0]                       r_col;
    logic [COORD_BITS-1:0]               r_row;
    logic                                r_finished;
    logic [pcxrle_pkg::COUNT_W-1:0]      r_left;
    logic                                r_out_valid;
    pcxrle_pkg::t_out_item               r_out_data;

    logic                                in_acc;
    logic                                is_img;
    logic                                is_count;
    logic                                pix_go;
    logic [CW-1:0]                       run_n;
    logic [CW-1:0]                       room;
    logic [CW-1:0]                       emit_sel;
    logic [pcxrle_pkg::COUNT_W-1:0]      n_left;
    logic [CW-1:0]                       col_p1;
    logic [CW-1:0]                       row_p1;
    logic                                out_free;
    logic                                push;
    pcxrle_pkg::t_out_item               n_out_data;

    always_comb begin
        in_acc   = i_in_valid && (r_state == ST_IDLE);
        is_img   = (i_in_data.func == pcxrle_pkg::FUNC_IMAGE);
        is_count = !r_await &&
                   ((i_in_data.data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
        pix_go   = in_acc && is_img && !r_finished && !is_count;
        run_n    = r_await ? CW'(r_pending) : CW'(1);
        room     = (r_col < i_width) ? (i_width - r_col) : '0;
        emit_sel = (run_n < room) ? run_n : room;
        n_left   = emit_sel[pcxrle_pkg::COUNT_W-1:0];
        col_p1   = r_col + CW'(1);
        row_p1   = {1'b0, r_row} + CW'(1);
        out_free = !r_out_valid || !i_out_stall;
        push     = (r_state == ST_EMIT) && out_free;

        n_out_data.red        = i_pal_rdata[23:16];
        n_out_data.green      = i_pal_rdata[15:8];
        n_out_data.blue       = i_pal_rdata[7:0];
        n_out_data.column     = pcxrle_pkg::OUT_COORD_W'(r_col[COORD_BITS-1:0]);
        n_out_data.row        = pcxrle_pkg::OUT_COORD_W'(r_row);
        n_out_data.run_last   = (r_left == pcxrle_pkg::COUNT_W'(1));
        n_out_data.image_done = (col_p1 == i_width) && (row_p1 >= i_height);

        o_pal_req.wr_en   = in_acc && !is_img;
        o_pal_req.wr_addr = i_in_data.palette_index;
        o_pal_req.wr_data = i_in_data.palette_color;
        o_pal_req.rd_en   = pix_go;
        o_pal_req.rd_addr = i_in_data.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_await     <= 1'b0;
            r_pending   <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_finished  <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && is_img && !r_finished) begin
                        if (is_count) begin
                            r_await   <= 1'b1;
                            r_pending <= i_in_data.data_byte[pcxrle_pkg::COUNT_W-1:0];
                        end else begin
                            r_await   <= 1'b0;
                            r_pending <= '0;
                            r_left    <= n_left;
                            r_state   <= (n_left == '0) ? ST_WRAP : ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (push) begin
                        r_col  <= col_p1;
                        r_left <= r_left - pcxrle_pkg::COUNT_W'(1);
                        if (r_left == pcxrle_pkg::COUNT_W'(1)) begin
                            r_state <= ST_WRAP;
                        end
                    end
                end
                ST_WRAP: begin
                    if (r_col >= i_width) begin
                        r_col <= '0;
                        if (row_p1 >= i_height) begin
                            r_finished <= 1'b1;
                            r_row      <= '0;
                        end else begin
                            r_row <= row_p1[COORD_BITS-1:0];
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_status.busy     = (r_state != ST_IDLE);
    assign o_status.finished = r_finished;
    assign o_status.push     = push;

endmodule

>>> rtl/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// Decodes 8-bit PCX run-length image bytes into RGB pixels via a palette.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall    o_out_data (t_out_item)
//   cfg       input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// palette writes and run count bytes do not stall the input
// a pixel byte runs palette read, one pixel per cycle unless the output stalls, row wrap
// the run counter and the output stall set the pixel rate
// synchronous active-low reset clears decode state and sets sizes to 320 x 200, not the palette
// output stall holds the run; input stall stays high until the byte is done
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder #(
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pcxrle_pkg::t_in_item             i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pcxrle_pkg::t_out_item            o_out_data,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [pcxrle_pkg::CFG_W-1:0] SIZE_LIMIT =
        pcxrle_pkg::CFG_W'(1) << COORD_BITS;

    logic [pcxrle_pkg::CFG_W-1:0]   r_width;
    logic [pcxrle_pkg::CFG_W-1:0]   r_height;
    logic [COORD_BITS:0]            width_c;
    logic [COORD_BITS:0]            height_c;
    pcxrle_pkg::t_pal_req           pal_req;
    logic [pcxrle_pkg::COLOR_W-1:0] pal_rdata;
    pcxrle_pkg::t_status            s_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pcxrle_pkg::WIDTH_RESET;
            r_height <= pcxrle_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcxrle_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                pcxrle_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp sizes to 1 .. 2^COORD_BITS
    always_comb begin
        if (r_width == '0) begin
            width_c = (COORD_BITS+1)'(1);
        end else if (r_width > SIZE_LIMIT) begin
            width_c = SIZE_LIMIT[COORD_BITS:0];
        end else begin
            width_c = r_width[COORD_BITS:0];
        end
        if (r_height == '0) begin
            height_c = (COORD_BITS+1)'(1);
        end else if (r_height > SIZE_LIMIT) begin
            height_c = SIZE_LIMIT[COORD_BITS:0];
        end else begin
            height_c = r_height[COORD_BITS:0];
        end
    end

    pcxrle_pal_ram u_pal_ram (
        .i_clk   (i_clk),
        .i_req   (pal_req),
        .o_rdata (pal_rdata)
    );

    pcxrle_ctl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_width     (width_c),
        .i_height    (height_c),
        .o_pal_req   (pal_req),
        .i_pal_rdata (pal_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_status    (s_stat)
    );

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.image_done) |-> o_out_data.run_last)
        else $error("image_done pixel is not the last of its transaction");

    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && s_stat.finished &&
         i_in_data.func == pcxrle_pkg::FUNC_IMAGE) |=> !s_stat.busy)
        else $error("image byte after finish started a run");

    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.push |=> o_out_valid)
        else $error("pixel pushed but output register not valid");
`endif

endmodule

>>> tb/pcx_rle_palette_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_tb
// Self-checking bench for the PCX run-length palette decoder. The palette
// entries of every code that the bench sends as an image byte are filled
// first. A directed table then covers literals, runs of zero and 63, a run
// value byte with its top bits set, size clamping and size changes in the
// middle of the image. Random phases follow, each with its own row width
// and height. The last phase shrinks the image so that it finishes, then
// sends image bytes that must be ignored and a palette write. Every pixel is checked against an
// in-bench decoder, with random stalls and one long output hold.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int NUM_CODES    = 12;
    localparam int NUM_LITERALS = 5;

    // codes sent as image bytes: literals first, then counts
    localparam logic [7:0] PIXEL_CODES [NUM_CODES] = '{
        8'h00, 8'h3C, 8'h7F, 8'h81, 8'hBF,
        8'hC0, 8'hC1, 8'hC3, 8'hC5, 8'hC7, 8'hCC, 8'hFF
    };

    typedef enum logic [1:0] {ROW_PAL, ROW_BYTE, ROW_WIDTH, ROW_HEIGHT} t_row_kind;

    // value: color, byte or register value; the pixel fields apply when typed is set
    typedef struct packed {
        t_row_kind   kind;
        logic [23:0] value;
        logic [7:0]  index;
        logic        typed;
        logic [23:0] rgb;
        logic [15:0] column;
        logic [15:0] row;
        logic        last;
        logic        done;
    } t_stim_row;

    localparam t_stim_row DIRECTED [24] = '{
        '{ROW_PAL,    24'h000000, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_PAL,    24'hFFFFFF, 8'hFF, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_PAL,    24'h00FF00, 8'hC5, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h000000, 8'h00, 1'b1, 24'h000000, 16'd0,  16'd0, 1'b1, 1'b0},
        '{ROW_BYTE,   24'h0000FF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000FF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000C0, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h00007F, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000C1, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000C5, 8'h00, 1'b1, 24'h00FF00, 16'd64, 16'd0, 1'b1, 1'b0},
        '{ROW_BYTE,   24'h0000BF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_WIDTH,  24'h000000, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h000000, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000FF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h000000, 8'h00, 1'b1, 24'h000000, 16'd0,  16'd1, 1'b1, 1'b0},
        '{ROW_WIDTH,  24'h01FFFF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_HEIGHT, 24'h01FFFF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000FF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h0000FF, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_WIDTH,  24'h010000, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_HEIGHT, 24'h010000, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h000000, 8'h00, 1'b1, 24'h000000, 16'd63, 16'd2, 1'b1, 1'b0},
        '{ROW_PAL,    24'h5A5A5A, 8'h00, 1'b0, 24'h000000, 16'd0,  16'd0, 1'b0, 1'b0},
        '{ROW_BYTE,   24'h000000, 8'h00, 1'b1, 24'h5A5A5A, 16'd64, 16'd2, 1'b1, 1'b0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    pcxrle_pkg::t_in_item         in_data;
    logic                         out_valid;
    logic                         out_stall;
    pcxrle_pkg::t_out_item        out_data;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [pcxrle_pkg::CFG_W-1:0] cfg_data;

    // decoder state mirrored by the bench
    logic [pcxrle_pkg::COLOR_W-1:0] pal_rgb [pcxrle_pkg::PAL_DEPTH];
    logic                           run_armed;
    logic [pcxrle_pkg::COUNT_W-1:0] run_len;
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    logic                           img_finished;
    logic [pcxrle_pkg::CFG_W-1:0]   width_reg;
    logic [pcxrle_pkg::CFG_W-1:0]   height_reg;

    pcxrle_pkg::t_out_item expected_pixels [$];
    int                    pixel_errors = 0;
    bit                    idle_jitter  = 1'b1;
    bit                    hold_req     = 1'b0;

    pcx_rle_palette_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int unsigned eff_size(logic [pcxrle_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > (1 << pcxrle_pkg::OUT_COORD_W)) return 1 << pcxrle_pkg::OUT_COORD_W;
        return 32'(v);
    endfunction

    function automatic void predict_pixels(pcxrle_pkg::t_in_item item);
        int unsigned n, w, h, col, row, room, emit, k;
        logic [pcxrle_pkg::COLOR_W-1:0] rgb;
        pcxrle_pkg::t_out_item px;
        if (item.func == pcxrle_pkg::FUNC_PALETTE) begin
            pal_rgb[item.palette_index] = item.palette_color;
            return;
        end
        if (img_finished) return;
        if (!run_armed &&
            (item.data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
            run_len   = item.data_byte[pcxrle_pkg::COUNT_W-1:0];
            run_armed = 1'b1;
            return;
        end
        n = run_armed ? 32'(run_len) : 1;
        run_armed = 1'b0;
        run_len   = '0;
        w    = eff_size(width_reg);
        h    = eff_size(height_reg);
        col  = col_pos;
        row  = row_pos;
        room = (col < w) ? w - col : 0;
        emit = (n < room) ? n : room;
        rgb  = pal_rgb[item.data_byte];
        for (k = 0; k < emit; k++) begin
            px.red        = rgb[23:16];
            px.green      = rgb[15:8];
            px.blue       = rgb[7:0];
            px.column     = col[pcxrle_pkg::OUT_COORD_W-1:0];
            px.row        = row[pcxrle_pkg::OUT_COORD_W-1:0];
            px.run_last   = (k + 1 == emit);
            col++;
            px.image_done = (col == w && row + 1 >= h);
            expected_pixels.push_back(px);
        end
        if (col >= w) begin
            col = 0;
            if (row + 1 >= h) begin
                img_finished = 1'b1;
                row = 0;
            end else begin
                row++;
            end
        end
        col_pos = col & 32'hFFFF;
        row_pos = row & 32'hFFFF;
    endfunction

    task automatic send_item(pcxrle_pkg::t_in_item item, bit typed = 1'b0,
                             pcxrle_pkg::t_out_item typed_px = '0);
        int base;
        base = expected_pixels.size();
        predict_pixels(item);
        if (typed) begin
            while (expected_pixels.size() > base)
                expected_pixels.delete(expected_pixels.size() - 1);
            expected_pixels.push_back(typed_px);
        end
        if (idle_jitter && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(logic idx, logic [pcxrle_pkg::CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pcxrle_pkg::CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    // mostly literals and count/value pairs, some palette writes and lone counts
    task automatic send_random_step();
        pcxrle_pkg::t_in_item item;
        int pick;
        item.func          = pcxrle_pkg::FUNC_IMAGE;
        item.data_byte     = PIXEL_CODES[$urandom_range(0, NUM_CODES - 1)];
        item.palette_index = 8'($urandom);
        item.palette_color = 24'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            item.func = pcxrle_pkg::FUNC_PALETTE;
            send_item(item);
        end else if (pick < 45) begin
            item.data_byte = PIXEL_CODES[$urandom_range(0, NUM_LITERALS - 1)];
            send_item(item);
        end else if (pick < 90) begin
            item.data_byte = PIXEL_CODES[$urandom_range(NUM_LITERALS, NUM_CODES - 1)];
            send_item(item);
            item.data_byte     = PIXEL_CODES[$urandom_range(0, NUM_CODES - 1)];
            item.palette_index = 8'($urandom);
            item.palette_color = 24'($urandom);
            send_item(item);
        end else begin
            item.data_byte = PIXEL_CODES[$urandom_range(NUM_LITERALS, NUM_CODES - 1)];
            send_item(item);
        end
    endtask

    // output side stalls
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_jitter && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_pixels
        pcxrle_pkg::t_out_item exp_px;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("%0t unexpected pixel rgb=%02h%02h%02h col=%0d row=%0d",
                             $realtime, out_data.red, out_data.green, out_data.blue,
                             out_data.column, out_data.row);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (out_data !== exp_px) begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display({"%0t pixel mismatch: expected rgb=%02h%02h%02h col=%0d row=%0d ",
                                  "last=%b done=%b, got rgb=%02h%02h%02h col=%0d row=%0d ",
                                  "last=%b done=%b"},
                                 $realtime, exp_px.red, exp_px.green, exp_px.blue,
                                 exp_px.column, exp_px.row, exp_px.run_last,
                                 exp_px.image_done, out_data.red, out_data.green,
                                 out_data.blue, out_data.column, out_data.row,
                                 out_data.run_last, out_data.image_done);
                end
            end
        end
    end

    initial begin
        pcxrle_pkg::t_in_item         item;
        pcxrle_pkg::t_out_item        px;
        t_stim_row                    srow;
        logic [pcxrle_pkg::CFG_W-1:0] w_sel, h_sel;
        int                           guard;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= pcxrle_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        run_armed    = 1'b0;
        run_len      = '0;
        col_pos      = 0;
        row_pos      = 0;
        img_finished = 1'b0;
        width_reg    = pcxrle_pkg::WIDTH_RESET;
        height_reg   = pcxrle_pkg::HEIGHT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every code that can be sent as an image byte gets a color first
        foreach (PIXEL_CODES[i]) begin
            item.func          = pcxrle_pkg::FUNC_PALETTE;
            item.data_byte     = 8'($urandom);
            item.palette_index = PIXEL_CODES[i];
            item.palette_color = 24'($urandom);
            send_item(item);
        end

        foreach (DIRECTED[r]) begin
            srow = DIRECTED[r];
            case (srow.kind)
                ROW_WIDTH: begin
                    write_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, srow.value[pcxrle_pkg::CFG_W-1:0]);
                end
                ROW_HEIGHT: begin
                    write_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, srow.value[pcxrle_pkg::CFG_W-1:0]);
                end
                default: begin
                    item.func          = (srow.kind == ROW_PAL) ? pcxrle_pkg::FUNC_PALETTE
                                                                : pcxrle_pkg::FUNC_IMAGE;
                    item.data_byte     = (srow.kind == ROW_BYTE) ? srow.value[7:0] : 8'($urandom);
                    item.palette_index = (srow.kind == ROW_PAL) ? srow.index : 8'($urandom);
                    item.palette_color = (srow.kind == ROW_PAL) ? srow.value : 24'($urandom);
                    px.red        = srow.rgb[23:16];
                    px.green      = srow.rgb[15:8];
                    px.blue       = srow.rgb[7:0];
                    px.column     = srow.column;
                    px.row        = srow.row;
                    px.run_last   = srow.last;
                    px.image_done = srow.done;
                    send_item(item, srow.typed, px);
                end
            endcase
        end

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       w_sel = pcxrle_pkg::CFG_W'($urandom_range(1, 12));
                1:       w_sel = pcxrle_pkg::CFG_W'($urandom_range(13, 600));
                2:       w_sel = pcxrle_pkg::CFG_W'($urandom_range(64, 2000));
                3:       w_sel = '0;
                4:       w_sel = '1;
                5:       w_sel = pcxrle_pkg::CFG_W'($urandom);
                default: w_sel = pcxrle_pkg::CFG_W'($urandom_range(1, 40));
            endcase
            h_sel = (ph == 4) ? '1 : pcxrle_pkg::CFG_W'($urandom_range(4096, 131071));
            write_reg(pcxrle_pkg::CFG_IMAGE_WIDTH, w_sel);
            write_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, h_sel);
            if (ph == 2) hold_req = 1'b1;
            repeat (7) send_random_step();
        end

        // final row: no idling, image completes, later image bytes are dropped
        idle_jitter = 1'b0;
        write_reg(pcxrle_pkg::CFG_IMAGE_WIDTH,
                  pcxrle_pkg::CFG_W'(col_pos + 1 + $urandom_range(0, 6)));
        write_reg(pcxrle_pkg::CFG_IMAGE_HEIGHT, '0);
        guard = 0;
        while (!img_finished && guard < 200) begin
            send_random_step();
            guard++;
        end
        for (int k = 0; k < 4; k++) begin
            item.func          = (k == 3) ? pcxrle_pkg::FUNC_PALETTE : pcxrle_pkg::FUNC_IMAGE;
            item.data_byte     = PIXEL_CODES[$urandom_range(0, NUM_CODES - 1)];
            item.palette_index = 8'($urandom);
            item.palette_color = 24'($urandom);
            send_item(item);
        end

        in_valid <= 1'b0;
        for (guard = 0; expected_pixels.size() != 0 && guard < 20000; guard++)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (expected_pixels.size() != 0) begin
            pixel_errors++;
            $display("%0d pixels never arrived", expected_pixels.size());
        end
        if (pixel_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> pcx_rle_palette_decoder.f
rtl/pcxrle_pkg.sv
rtl/pcxrle_pal_ram.sv
rtl/pcxrle_ctl.sv
rtl/pcx_rle_palette_decoder.sv
tb/pcx_rle_palette_decoder_tb.sv
